FILE: rtl/faplru_pkg.sv
// Package for the fully associative tree-PLRU cache lookup.
// Sizes, controller state encoding and controller/datapath bundles.
// No dependencies.
`default_nettype none

package faplru_pkg;

  localparam int NUM_WAYS   = 512;
  localparam int LINE_BYTES = 32;
  localparam int ADDR_W     = 32;
  localparam int WAY_W      = 9;
  localparam int OFFSET_W   = $clog2(LINE_BYTES);
  localparam int TAG_W      = ADDR_W - OFFSET_W;
  localparam int LEVELS     = $clog2(NUM_WAYS);
  localparam int TREE_NODES = NUM_WAYS - 1;
  localparam int TREE_AW    = $clog2(TREE_NODES);
  localparam int NODE_W     = TREE_AW + 1;
  localparam int CNT_W      = $clog2(NUM_WAYS + 1);
  localparam int LVL_W      = $clog2(LEVELS);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_WALK_REQ = 7'b0001000,
    S_WALK_USE = 7'b0010000,
    S_TOUCH    = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load_in;
    logic scan_en;
    logic walk_use;
    logic touch_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic scan_hit;
    logic lvl_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/faplru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module faplru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/faplru_ctrl.sv
// Controller for the cache lookup: clear pass, tag scan, victim walk,
// tree touch and result hand-off. Depends on faplru_pkg.
`default_nettype none

module faplru_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              addr_valid,
  output logic                   addr_ready,
  input  wire faplru_pkg::sts_t  sts,
  output faplru_pkg::cmd_t       cmd
);

  faplru_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= faplru_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      faplru_pkg::S_CLEAR: begin
        if (sts.clr_done) state_next = faplru_pkg::S_IDLE;
      end
      faplru_pkg::S_IDLE: begin
        if (addr_valid) state_next = faplru_pkg::S_SCAN;
      end
      faplru_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_next = sts.scan_hit ? faplru_pkg::S_TOUCH : faplru_pkg::S_WALK_REQ;
        end
      end
      faplru_pkg::S_WALK_REQ: begin
        state_next = faplru_pkg::S_WALK_USE;
      end
      faplru_pkg::S_WALK_USE: begin
        state_next = sts.lvl_last ? faplru_pkg::S_TOUCH : faplru_pkg::S_WALK_REQ;
      end
      faplru_pkg::S_TOUCH: begin
        if (sts.lvl_last) state_next = faplru_pkg::S_FINISH;
      end
      faplru_pkg::S_FINISH: begin
        if (sts.out_free) state_next = faplru_pkg::S_IDLE;
      end
      default: state_next = faplru_pkg::S_CLEAR;
    endcase
  end

  assign addr_ready   = (state == faplru_pkg::S_IDLE);
  assign cmd.clr_en   = (state == faplru_pkg::S_CLEAR);
  assign cmd.load_in  = (state == faplru_pkg::S_IDLE) && addr_valid;
  assign cmd.scan_en  = (state == faplru_pkg::S_SCAN);
  assign cmd.walk_use = (state == faplru_pkg::S_WALK_USE);
  assign cmd.touch_en = (state == faplru_pkg::S_TOUCH);
  assign cmd.out_load = (state == faplru_pkg::S_FINISH) && sts.out_free;

endmodule

`default_nettype wire

FILE: rtl/faplru_dp.sv
// Datapath for the cache lookup: tag RAM, PLRU tree RAM, scan and level
// counters, and the result register. Depends on faplru_pkg and faplru_ram.
`default_nettype none

module faplru_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [faplru_pkg::ADDR_W-1:0]     byte_address,
  input  wire faplru_pkg::cmd_t                  cmd,
  output faplru_pkg::sts_t                       sts,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic                                   hit,
  output logic [faplru_pkg::WAY_W-1:0]           way_used
);

  logic [faplru_pkg::CNT_W-1:0]   cnt;
  logic                           cmp_vld;
  logic [faplru_pkg::LEVELS-1:0]  cmp_idx;
  logic [faplru_pkg::TAG_W-1:0]   tag;
  logic                           found;
  logic [faplru_pkg::LEVELS-1:0]  way;
  logic [faplru_pkg::NODE_W-1:0]  node;
  logic [faplru_pkg::LVL_W-1:0]   lvl;

  logic                           tag_we;
  logic [faplru_pkg::LEVELS-1:0]  tag_waddr;
  logic [faplru_pkg::TAG_W-1:0]   tag_wdata;
  logic [faplru_pkg::TAG_W-1:0]   tag_rdata;
  logic                           tree_we;
  logic [faplru_pkg::TREE_AW-1:0] tree_waddr;
  logic [0:0]                     tree_wdata;
  logic [0:0]                     tree_rdata;

  logic                           match;
  logic                           scan_end;
  logic [faplru_pkg::LEVELS-1:0]  walk_way;
  logic [faplru_pkg::LEVELS-1:0]  victim;
  logic [faplru_pkg::LVL_W-1:0]   touch_idx;
  logic                           touch_dir;
  logic                           lvl_last;

  faplru_ram #(
    .WIDTH(faplru_pkg::TAG_W),
    .DEPTH(faplru_pkg::NUM_WAYS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(tag_waddr),
    .wdata(tag_wdata),
    .raddr(cnt[faplru_pkg::LEVELS-1:0]),
    .rdata(tag_rdata)
  );

  faplru_ram #(
    .WIDTH(1),
    .DEPTH(faplru_pkg::TREE_NODES)
  ) u_tree_ram (
    .clk  (clk),
    .we   (tree_we),
    .waddr(tree_waddr),
    .wdata(tree_wdata),
    .raddr(node[faplru_pkg::TREE_AW-1:0]),
    .rdata(tree_rdata)
  );

  always_comb begin
    match     = cmp_vld && (tag_rdata == tag);
    scan_end  = cmp_vld && (cmp_idx == faplru_pkg::LEVELS'(faplru_pkg::NUM_WAYS - 1));
    walk_way  = {way[faplru_pkg::LEVELS-2:0], tree_rdata[0]};
    // walk past the last way clamps to it
    victim    = ({1'b0, walk_way} >= (faplru_pkg::LEVELS + 1)'(faplru_pkg::NUM_WAYS)) ?
                faplru_pkg::LEVELS'(faplru_pkg::NUM_WAYS - 1) : walk_way;
    touch_idx = faplru_pkg::LVL_W'(faplru_pkg::LEVELS - 1) - lvl;
    touch_dir = way[touch_idx];
    lvl_last  = (lvl == faplru_pkg::LVL_W'(faplru_pkg::LEVELS - 1));

    tag_we    = cmd.clr_en || (cmd.touch_en && !found && (lvl == '0));
    tag_waddr = cmd.clr_en ? cnt[faplru_pkg::LEVELS-1:0] : way;
    tag_wdata = cmd.clr_en ? '0 : tag;

    tree_we    = (cmd.clr_en && (cnt < faplru_pkg::CNT_W'(faplru_pkg::TREE_NODES))) ||
                 cmd.touch_en;
    tree_waddr = cmd.clr_en ? cnt[faplru_pkg::TREE_AW-1:0] : node[faplru_pkg::TREE_AW-1:0];
    tree_wdata = cmd.clr_en ? 1'b0 : ~touch_dir;
  end

  assign sts.clr_done  = (cnt == faplru_pkg::CNT_W'(faplru_pkg::NUM_WAYS - 1));
  assign sts.scan_done = match || scan_end;
  assign sts.scan_hit  = match;
  assign sts.lvl_last  = lvl_last;
  assign sts.out_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      cmp_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        cnt <= cnt + faplru_pkg::CNT_W'(1);
      end
      if (cmd.load_in) begin
        cnt     <= '0;
        cmp_vld <= 1'b0;
      end
      if (cmd.scan_en) begin
        if (cnt < faplru_pkg::CNT_W'(faplru_pkg::NUM_WAYS)) begin
          cnt     <= cnt + faplru_pkg::CNT_W'(1);
          cmp_vld <= 1'b1;
        end else begin
          cmp_vld <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tag <= byte_address[faplru_pkg::ADDR_W-1:faplru_pkg::OFFSET_W];
    end
    if (cmd.scan_en) begin
      cmp_idx <= cnt[faplru_pkg::LEVELS-1:0];
      if (sts.scan_done) begin
        found <= match;
        way   <= match ? cmp_idx : '0;
        node  <= '0;
        lvl   <= '0;
      end
    end
    if (cmd.walk_use) begin
      if (lvl_last) begin
        way  <= victim;
        node <= '0;
        lvl  <= '0;
      end else begin
        way  <= walk_way;
        node <= {node[faplru_pkg::NODE_W-2:0], 1'b0} + faplru_pkg::NODE_W'(1) +
                faplru_pkg::NODE_W'(tree_rdata[0]);
        lvl  <= lvl + faplru_pkg::LVL_W'(1);
      end
    end
    if (cmd.touch_en) begin
      node <= {node[faplru_pkg::NODE_W-2:0], 1'b0} + faplru_pkg::NODE_W'(1) +
              faplru_pkg::NODE_W'(touch_dir);
      lvl  <= lvl + faplru_pkg::LVL_W'(1);
    end
    if (cmd.out_load) begin
      hit      <= found;
      way_used <= faplru_pkg::WAY_W'(way);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fully_assoc_tree_plru_cache_lookup.sv
// Top level of the fully associative tree-PLRU cache lookup.
// Depends on faplru_pkg, faplru_ctrl, faplru_dp.
//
// Each byte_address word is looked up against 512 block tags (address / 32)
// held in a single tag RAM that is scanned one way per cycle, lowest way
// first. A hit stops the scan at the matching way; a miss scans all ways and
// walks the nine-level PLRU tree held in its own RAM (a request state and a
// use state per level for the registered read). Either way nine tree bits are
// then rewritten. The scan through the tag RAM port sets the rate. One word
// is in work at a time; a new one is taken while the previous result still
// waits in the output register. After reset a clearing pass zeroes tags and
// tree before the first word is taken.
`default_nettype none

module fully_assoc_tree_plru_cache_lookup (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          addr_valid,
  output logic                               addr_ready,
  input  wire logic [faplru_pkg::ADDR_W-1:0] byte_address,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic                               hit,
  output logic [faplru_pkg::WAY_W-1:0]       way_used
);

  faplru_pkg::cmd_t cmd;
  faplru_pkg::sts_t sts;

  faplru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .addr_valid(addr_valid),
    .addr_ready(addr_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  faplru_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .byte_address(byte_address),
    .cmd         (cmd),
    .sts         (sts),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .hit         (hit),
    .way_used    (way_used)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || result_ready))
    else $error("result register loaded while still held");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (addr_valid && addr_ready) |=> !addr_ready)
    else $error("second word taken while lookup in progress");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");
`endif

endmodule

`default_nettype wire

FILE: tb/fully_assoc_tree_plru_cache_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench for fully_assoc_tree_plru_cache_lookup: directed and random address streams,
// each result checked against a local tag store and PLRU tree predictor.
// Depends on faplru_pkg and the RTL top level.
module fully_assoc_tree_plru_cache_lookup_tb;

  typedef struct {
    logic                         hit;
    logic [faplru_pkg::WAY_W-1:0] way;
  } lookup_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          addr_valid;
  logic                          addr_ready;
  logic [faplru_pkg::ADDR_W-1:0] byte_address;
  logic                          result_valid;
  logic                          result_ready;
  logic                          hit;
  logic [faplru_pkg::WAY_W-1:0]  way_used;

  logic [faplru_pkg::TAG_W-1:0]  tag_store [faplru_pkg::NUM_WAYS];
  logic                          plru_bits [faplru_pkg::TREE_NODES];
  lookup_t                       pending_lookups [$];
  logic [faplru_pkg::ADDR_W-1:0] seen_addrs [$];
  int                            errors = 0;
  bit                            steady = 1'b0;

  fully_assoc_tree_plru_cache_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .addr_valid   (addr_valid),
    .addr_ready   (addr_ready),
    .byte_address (byte_address),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hit          (hit),
    .way_used     (way_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest matching way wins; on a miss walk the tree for the victim, then point the path away
  function automatic lookup_t predict_lookup(input logic [faplru_pkg::ADDR_W-1:0] addr);
    lookup_t                      r;
    logic [faplru_pkg::TAG_W-1:0] tag;
    int                           node;
    int                           i;
    tag   = addr[faplru_pkg::ADDR_W-1:faplru_pkg::OFFSET_W];
    r.hit = 1'b0;
    r.way = '0;
    for (i = faplru_pkg::NUM_WAYS - 1; i >= 0; i--) begin
      if (tag_store[i] == tag) begin
        r.hit = 1'b1;
        r.way = faplru_pkg::WAY_W'(i);
      end
    end
    if (!r.hit) begin
      node = 0;
      for (i = 0; i < faplru_pkg::LEVELS; i++) begin
        r.way = {r.way[faplru_pkg::WAY_W-2:0], plru_bits[node]};
        node  = 2 * node + 1 + int'(plru_bits[node]);
      end
      tag_store[r.way] = tag;
    end
    node = 0;
    for (i = faplru_pkg::LEVELS - 1; i >= 0; i--) begin
      plru_bits[node] = ~r.way[i];
      node = 2 * node + 1 + int'(r.way[i]);
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  // earlier address from the last depth words, with fresh offset bits
  function automatic logic [faplru_pkg::ADDR_W-1:0] reuse_address(input int depth);
    logic [faplru_pkg::ADDR_W-1:0] a;
    int                            lo;
    lo = (seen_addrs.size() > depth) ? seen_addrs.size() - depth : 0;
    a  = seen_addrs[$urandom_range(lo, seen_addrs.size() - 1)];
    a[faplru_pkg::OFFSET_W-1:0] = faplru_pkg::OFFSET_W'($urandom());
    return a;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic send_address(input logic [faplru_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      addr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    addr_valid   <= 1'b1;
    byte_address <= addr;
    do @(posedge clk); while (!addr_ready);
    pending_lookups.push_back(predict_lookup(addr));
    seen_addrs.push_back(addr);
  endtask

  task automatic test_block_zero_at_reset();
    send_address(32'h0000_0000);
    send_address(32'h0000_001F);
    send_address(32'h0000_0010);
  endtask

  task automatic test_address_extremes();
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFE0);
    send_address(32'h8000_0000);
    send_address(32'h7FFF_FFFF);
    send_address(32'h0000_0020);
    send_address(32'hAAAA_AAAA);
    send_address(32'h5555_5555);
    send_address(32'h0000_0000);
  endtask

  task automatic test_hit_after_fill();
    send_address(32'h8000_001F);
    send_address(32'h5555_5540);
    send_address(32'hFFFF_FFE7);
    send_address(32'h0000_003F);
  endtask

  task automatic test_tree_walk();
    int k;
    for (k = 0; k < 6; k++) send_address(32'h1234_0000 + k * 32'h0001_0020);
    for (k = 5; k >= 0; k--) send_address(32'h1234_001F + k * 32'h0001_0020);
  endtask

  // mostly fresh blocks so the victim walk cycles through the whole tree
  task automatic test_random_churn(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 8) send_address(reuse_address(8));
      else send_address($urandom());
    end
  endtask

  task automatic test_random_mixed(input int count);
    int                            n;
    logic [faplru_pkg::ADDR_W-1:0] a;
    for (n = 0; n < count; n++) begin
      if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9)) inside
        [0:3]:   a = reuse_address(seen_addrs.size());
        [4:6]:   a = $urandom();
        7:       a = {{faplru_pkg::TAG_W{1'b0}}, faplru_pkg::OFFSET_W'($urandom())};
        8:       a = reuse_address(64) + 32'd32;
        default: begin
          a = 32'h1 << $urandom_range(faplru_pkg::OFFSET_W, faplru_pkg::ADDR_W - 1);
        end
      endcase
      send_address(a);
    end
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected word hit=%0b way=%0d", hit, way_used));
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit)
          report_mismatch($sformatf("hit got %0b want %0b (way %0d)", hit, want.hit, want.way));
        if (way_used !== want.way)
          report_mismatch($sformatf("way_used got %0d want %0d", way_used, want.way));
      end
    end
  end

  initial begin
    int stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin
    int i;
    for (i = 0; i < faplru_pkg::NUM_WAYS; i++) tag_store[i] = '0;
    for (i = 0; i < faplru_pkg::TREE_NODES; i++) plru_bits[i] = 1'b0;
    rst          <= 1'b1;
    addr_valid   <= 1'b0;
    byte_address <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_block_zero_at_reset();
    test_address_extremes();
    test_hit_after_fill();
    test_tree_walk();
    test_random_churn(500);
    test_random_mixed(150);
    addr_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/faplru_pkg.sv
rtl/faplru_ram.sv
rtl/faplru_ctrl.sv
rtl/faplru_dp.sv
rtl/fully_assoc_tree_plru_cache_lookup.sv
tb/fully_assoc_tree_plru_cache_lookup_tb.sv
